>>> hdl/mcr_pkg.sv
// shared types, codes and constants of the modem card register block
`default_nettype none
package mcr_pkg;

  localparam int TIME_BITS = 48;
  localparam int CNT_W     = $clog2(TIME_BITS + 1);
  localparam int CLK_W     = 22;
  localparam int MS_W      = 13;
  localparam int HZ_W      = 12;
  localparam int PER_W     = 22;
  localparam int RING_W    = 25;
  localparam int DLY_W     = 27;
  localparam int CFG_IDX_W = 4;

  // request types
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TIME  = 2'd2;
  localparam logic [1:0] REQ_SPARE = 2'd3;

  // port offsets
  localparam logic [1:0] PORT_CTRL0 = 2'd0;
  localparam logic [1:0] PORT_DATA  = 2'd1;
  localparam logic [1:0] PORT_RATE  = 2'd2;
  localparam logic [1:0] PORT_CTRL3 = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAN_DIAL      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAN_ANSWER    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODEM_PRESENT = 4'd3;

  // divider operations
  localparam logic [2:0] DIV_RING = 3'd1;
  localparam logic [2:0] DIV_HZ   = 3'd2;
  localparam logic [2:0] DIV_PER  = 3'd3;
  localparam logic [2:0] DIV_TIM  = 3'd4;

  localparam int CLOCK_HZ_RESET = 2000000;
  localparam int MS_RECIP       = 536871; // ceil(2^26 / 125), ms = ((hz >> 3) * r) >> 26
  localparam int TIMER_NUM      = 2500;   // 250000 / 100
  localparam int DUR_CTS_ORIG   = 750;
  localparam int DUR_CTS_ANS    = 2450;   // 2000 + 450
  localparam int DUR_AP_RESET   = 1500;
  localparam int DUR_NO_HSHAKE  = 17000;
  localparam int DUR_RING_ON    = 2000;
  localparam int DUR_RING_CYC   = 6000;

  localparam logic [7:0] STATUS_FIXED = 8'h43;
  localparam logic [7:0] READ_EMPTY   = 8'hFF;
  localparam int C3_DTR_BIT = 6;   // 0x40
  localparam int C3_ST_BIT  = 4;   // 0x10

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] port_offset;
    logic [7:0] write_data;
    logic [15:0] elapsed;
    logic       carrier;
    logic       ringing;
    logic       connecting;
    logic [4:0] uart_flags;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_strobe;
    logic       rx_strobe;
    logic       dial_cmd;
    logic       answer_cmd;
    logic       hangup_cmd;
    logic       arm_answer_cmd;
    logic       self_test_loop;
    logic [3:0] data_bits;
    logic [1:0] parity_mode;
    logic       two_stop;
    logic [7:0] rate_divisor;
  } res_t;

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic [2:0] div_op;
    logic       mul_load;
    logic       adv;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic stat_need;
    logic ring_need;
    logic rate_nz;
    logic hz_nz;
    logic per_nz;
  } stat_t;

  function automatic logic self_test(input logic [7:0] c3);
    return c3[C3_DTR_BIT] && !c3[C3_ST_BIT];
  endfunction

endpackage
`default_nettype wire

>>> hdl/mcr_if.sv
// channel interfaces: input items, result items, configuration writes
`default_nettype none
interface mcr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [1:0] port_offset;
  logic [7:0] write_data;
  logic [15:0] elapsed;
  logic       carrier;
  logic       ringing;
  logic       connecting;
  logic [4:0] uart_flags;
  logic [7:0] rx_byte;
  modport source (output valid, req_type, port_offset, write_data, elapsed, carrier,
                  ringing, connecting, uart_flags, rx_byte, input ready);
  modport sink (input valid, req_type, port_offset, write_data, elapsed, carrier,
                ringing, connecting, uart_flags, rx_byte, output ready);
endinterface

interface mcr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       tx_strobe;
  logic       rx_strobe;
  logic       dial_cmd;
  logic       answer_cmd;
  logic       hangup_cmd;
  logic       arm_answer_cmd;
  logic       self_test_loop;
  logic [3:0] data_bits;
  logic [1:0] parity_mode;
  logic       two_stop;
  logic [7:0] rate_divisor;
  modport source (output valid, read_data, tx_strobe, rx_strobe, dial_cmd, answer_cmd,
                  hangup_cmd, arm_answer_cmd, self_test_loop, data_bits, parity_mode,
                  two_stop, rate_divisor, input ready);
  modport sink (input valid, read_data, tx_strobe, rx_strobe, dial_cmd, answer_cmd,
                hangup_cmd, arm_answer_cmd, self_test_loop, data_bits, parity_mode,
                two_stop, rate_divisor, output ready);
endinterface

interface mcr_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [21:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hdl/mcr_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module mcr_div
  import mcr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [TIME_BITS-1:0] dividend,
  input  wire logic [TIME_BITS-1:0] divisor,
  output logic                      done,
  output logic [TIME_BITS-1:0]      quotient,
  output logic [TIME_BITS-1:0]      remainder
);

  logic [CNT_W-1:0]     cnt_r;
  logic                 done_r;
  logic [TIME_BITS-1:0] quo_r;
  logic [TIME_BITS-1:0] rem_r;
  logic [TIME_BITS-1:0] dvs_r;
  logic [TIME_BITS:0]   shifted;
  logic                 fits;

  assign shifted = {rem_r, quo_r[TIME_BITS-1]};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(TIME_BITS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[TIME_BITS-2:0], fits};
      rem_r <= fits ? TIME_BITS'(shifted - {1'b0, dvs_r}) : shifted[TIME_BITS-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

>>> hdl/mcr_ctrl.sv
// sequencer: item intake, divider steps, state commit and result slot
`default_nettype none
module mcr_ctrl
  import mcr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_RGW  = 4'd5;
  localparam logic [3:0] S_HZG  = 4'd6;
  localparam logic [3:0] S_HZW  = 4'd7;
  localparam logic [3:0] S_PRG  = 4'd8;
  localparam logic [3:0] S_PRW  = 4'd9;
  localparam logic [3:0] S_TMG  = 4'd10;
  localparam logic [3:0] S_TMW  = 4'd11;
  localparam logic [3:0] S_ADV  = 4'd12;
  localparam logic [3:0] S_EXE  = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic       oval_r, oval_nxt;
  logic       slot_free;

  assign slot_free = !oval_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = oval_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = S_CHK;
      end
      S_CHK: begin
        if (stat.stat_need && stat.ring_need) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = DIV_RING;
          state_nxt     = S_RGW;
        end else if (stat.stat_need && stat.rate_nz) begin
          state_nxt = S_HZG;
        end else begin
          state_nxt = S_ADV;
        end
      end
      S_RGW: begin
        if (stat.div_done) state_nxt = stat.rate_nz ? S_HZG : S_ADV;
      end
      S_HZG: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_HZ;
        state_nxt     = S_HZW;
      end
      S_HZW: begin
        if (stat.div_done) state_nxt = S_PRG;
      end
      S_PRG: begin
        if (stat.hz_nz) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = DIV_PER;
          state_nxt     = S_PRW;
        end else begin
          state_nxt = S_ADV;
        end
      end
      S_PRW: begin
        if (stat.div_done) state_nxt = S_TMG;
      end
      S_TMG: begin
        if (stat.per_nz) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = DIV_TIM;
          state_nxt     = S_TMW;
        end else begin
          state_nxt = S_ADV;
        end
      end
      S_TMW: begin
        if (stat.div_done) state_nxt = S_ADV;
      end
      S_ADV: begin
        cmd.adv   = 1'b1;
        state_nxt = S_EXE;
      end
      S_EXE: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    oval_nxt = oval_r;
    if (oval_r && out_ready) oval_nxt = 1'b0;
    if (cmd.commit) oval_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/mcr_dp.sv
// datapath: shadows, handshake timers, divider operands and result payload
`default_nettype none
module mcr_dp
  import mcr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cmd_t                 cmd,
  output stat_t                     stat,
  input  wire item_t                item,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CLK_W-1:0]     cfg_data,
  output res_t                      res
);

  // configuration
  logic [CLK_W-1:0] clock_hz_r;
  logic can_dial_r, can_answer_r, modem_present_r;

  // item
  item_t it_r;

  // block state
  logic [7:0] cz_r, rs_r, ct_r, dv_r;
  logic [TIME_BITS-1:0] tn_r, cts_r, ring_start_r, apr_r, hto_r;
  logic ap_r, om_r, cb_r, rb_r;

  // divider results and derived delays
  logic [2:0]        op_r;
  logic [MS_W-1:0]   ms_r;
  logic [RING_W-1:0] ring_rem_r;
  logic [HZ_W-1:0]   hz_r;
  logic [PER_W-1:0]  per_r;
  logic [PER_W-1:0]  tim_rem_r;
  logic [DLY_W-1:0]  d750_r, d2450_r, d1500_r, d17000_r, d2000_r, d6000_r;
  logic [DLY_W-1:0]  ms_ext;
  logic [38:0]       ms_prod;

  logic [TIME_BITS-1:0] div_a, div_b, div_q, div_rem;
  logic div_done;

  res_t res_r;

  mcr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  always_comb begin
    case (cmd.div_op)
      DIV_RING: begin
        div_a = tn_r - ring_start_r;
        div_b = TIME_BITS'(d6000_r);
      end
      DIV_HZ: begin
        div_a = TIME_BITS'(TIMER_NUM);
        div_b = TIME_BITS'(rs_r);
      end
      DIV_PER: begin
        div_a = TIME_BITS'(clock_hz_r);
        div_b = TIME_BITS'(hz_r);
      end
      DIV_TIM: begin
        div_a = tn_r;
        div_b = TIME_BITS'(per_r);
      end
      default: begin
        div_a = '0;
        div_b = '0;
      end
    endcase
  end

  // status toward the sequencer
  logic act_cur;
  assign act_cur = modem_present_r && (can_dial_r || can_answer_r) && !self_test(ct_r);

  always_comb begin
    stat.div_done  = div_done;
    stat.stat_need = (it_r.req_type == REQ_READ) && (it_r.port_offset == PORT_RATE)
                     && act_cur;
    stat.ring_need = it_r.ringing && (d6000_r != '0);
    stat.rate_nz   = rs_r != '0;
    stat.hz_nz     = hz_r != '0;
    stat.per_nz    = per_r != '0;
  end

  // ticks per millisecond: clock_hz / 1000 taken as (clock_hz / 8) / 125 by reciprocal
  assign ms_prod = {20'b0, clock_hz_r[CLK_W-1:3]} * 39'(MS_RECIP);
  assign ms_ext  = DLY_W'(ms_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_r <= item;
      ms_r <= ms_prod[26 +: MS_W];
    end
    if (cmd.div_start) op_r <= cmd.div_op;
    if (div_done) begin
      case (op_r)
        DIV_RING: ring_rem_r <= div_rem[RING_W-1:0];
        DIV_HZ:   hz_r       <= div_q[HZ_W-1:0];
        DIV_PER:  per_r      <= div_q[PER_W-1:0];
        DIV_TIM:  tim_rem_r  <= div_rem[PER_W-1:0];
        default: ;
      endcase
    end
    if (cmd.mul_load) begin
      d750_r   <= ms_ext * DLY_W'(DUR_CTS_ORIG);
      d2450_r  <= ms_ext * DLY_W'(DUR_CTS_ANS);
      d1500_r  <= ms_ext * DLY_W'(DUR_AP_RESET);
      d17000_r <= ms_ext * DLY_W'(DUR_NO_HSHAKE);
      d2000_r  <= ms_ext * DLY_W'(DUR_RING_ON);
      d6000_r  <= ms_ext * DLY_W'(DUR_RING_CYC);
    end
  end

  // modem status byte
  logic tone, cts_ok, ring_on, timer_hi;
  logic [7:0] modem_stat, uart_stat;

  always_comb begin
    tone     = can_dial_r && cz_r[0] && !it_r.carrier && !it_r.connecting;
    cts_ok   = (cts_r != '0) && (tn_r >= cts_r) && it_r.carrier;
    ring_on  = (d6000_r == '0) || ({2'b0, ring_rem_r} < d2000_r);
    timer_hi = (rs_r != '0) && (hz_r != '0) && (per_r != '0)
               && ((({4'b0, tim_rem_r} + 26'd1) * 26'd5) <= {3'b0, per_r, 1'b0});
    if (!act_cur) begin
      modem_stat = STATUS_FIXED;
    end else begin
      modem_stat = {timer_hi, om_r, 1'b0, !ap_r, 1'b0, !cts_ok,
                    !(it_r.ringing && ring_on), !tone};
    end
    uart_stat = {2'b0, it_r.uart_flags[4:2], it_r.uart_flags[0], it_r.uart_flags[1:0]};
  end

  // item effect
  logic [7:0] c0, c3;
  logic [TIME_BITS-1:0] cts, rst_t, apr, hto;
  logic ap, om, cb, rb, act, refr, idle_ln;
  logic pd, pa, ph, parm, tx, rx;
  logic [7:0] rd, rs, dv;
  res_t res_nxt;

  always_comb begin
    c0 = cz_r; c3 = ct_r; rs = rs_r; dv = dv_r;
    cts = cts_r; rst_t = ring_start_r; apr = apr_r; hto = hto_r;
    ap = ap_r; om = om_r; cb = cb_r; rb = rb_r;
    pd = 1'b0; pa = 1'b0; ph = 1'b0; parm = 1'b0; tx = 1'b0; rx = 1'b0;
    rd = '0; refr = 1'b0;
    idle_ln = !it_r.ringing && !it_r.connecting && !it_r.carrier;
    if (it_r.req_type == REQ_WRITE && it_r.port_offset == PORT_CTRL3) c3 = it_r.write_data;
    act = modem_present_r && (can_dial_r || can_answer_r) && !self_test(c3);

    case (it_r.req_type)
      REQ_READ: begin
        case (it_r.port_offset)
          PORT_CTRL0: rd = uart_stat;
          PORT_DATA: begin
            rd = it_r.rx_byte;
            rx = 1'b1;
          end
          PORT_RATE: rd = modem_stat;
          default:   rd = READ_EMPTY;
        endcase
      end
      REQ_WRITE: begin
        case (it_r.port_offset)
          PORT_DATA: tx = 1'b1;
          PORT_RATE: begin
            rs = it_r.write_data;
            if (it_r.write_data != '0) dv = it_r.write_data;
          end
          PORT_CTRL3: begin
            if (act) begin
              if (c3[C3_DTR_BIT] && !ct_r[C3_DTR_BIT]) begin
                if (can_answer_r) parm = 1'b1;
                if (c0[0] && can_dial_r && idle_ln) begin
                  pd = 1'b1;
                  om = 1'b1;
                end
              end
              if (!c3[C3_DTR_BIT] && ct_r[C3_DTR_BIT]) begin
                ph = 1'b1; ap = 1'b0; cts = '0; apr = '0; hto = '0;
              end
              if ((c0[1:0] != '0) && c3[C3_DTR_BIT]) ap = 1'b1;
            end
            refr = 1'b1;
          end
          default: begin
            c0 = it_r.write_data;
            if (act) begin
              if (c0[1] && !cz_r[1] && it_r.ringing) begin
                pa = 1'b1;
                om = 1'b0;
              end
              if (c0[0] && !cz_r[0] && c3[C3_DTR_BIT] && can_dial_r && !c0[1] && idle_ln)
              begin
                pd = 1'b1;
                om = 1'b1;
              end
              if ((c0[1:0] != '0) && c3[C3_DTR_BIT]) ap = 1'b1;
            end
            refr = 1'b1;
          end
        endcase
      end
      REQ_TIME: refr = 1'b1;
      default: ;
    endcase

    if (refr && act) begin
      if (it_r.carrier && !cb) begin
        cts = tn_r + TIME_BITS'(om ? d750_r : d2450_r);
        hto = '0;
      end else if (!it_r.carrier && cb) begin
        cts = '0;
        if (ap) apr = tn_r + TIME_BITS'(d1500_r);
      end
      cb = it_r.carrier;
      if (it_r.ringing && !rb) rst_t = tn_r;
      rb = it_r.ringing;
      if (apr != '0 && tn_r >= apr) begin
        ap = 1'b0;
        apr = '0;
      end
      if (hto != '0 && tn_r >= hto) begin
        ph = 1'b1; ap = 1'b0; hto = '0; cts = '0;
      end
      if (ap && !it_r.carrier && cts == '0) begin
        if (hto == '0) hto = tn_r + TIME_BITS'(d17000_r);
      end else if (it_r.carrier) begin
        hto = '0;
      end
    end

    res_nxt.read_data      = rd;
    res_nxt.tx_strobe      = tx;
    res_nxt.rx_strobe      = rx;
    res_nxt.dial_cmd       = pd;
    res_nxt.answer_cmd     = pa;
    res_nxt.hangup_cmd     = ph;
    res_nxt.arm_answer_cmd = parm;
    res_nxt.self_test_loop = self_test(c3);
    res_nxt.data_bits      = 4'd5 + {2'b0, c0[3:2]};
    res_nxt.parity_mode    = c0[4] ? 2'd0 : (c0[5] ? 2'd2 : 2'd1);
    res_nxt.two_stop       = c0[6];
    res_nxt.rate_divisor   = dv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r      <= CLK_W'(CLOCK_HZ_RESET);
      can_dial_r      <= 1'b0;
      can_answer_r    <= 1'b0;
      modem_present_r <= 1'b0;
      cz_r <= '0; rs_r <= '0; ct_r <= '0; dv_r <= '0;
      tn_r <= '0; cts_r <= '0; ring_start_r <= '0; apr_r <= '0; hto_r <= '0;
      ap_r <= 1'b0; om_r <= 1'b1; cb_r <= 1'b0; rb_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CLOCK_HZ:      clock_hz_r      <= cfg_data;
          CFG_CAN_DIAL:      can_dial_r      <= cfg_data[0];
          CFG_CAN_ANSWER:    can_answer_r    <= cfg_data[0];
          CFG_MODEM_PRESENT: modem_present_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.adv && it_r.req_type == REQ_TIME) tn_r <= tn_r + TIME_BITS'(it_r.elapsed);
      if (cmd.commit) begin
        cz_r <= c0; rs_r <= rs; ct_r <= c3; dv_r <= dv;
        cts_r <= cts; ring_start_r <= rst_t; apr_r <= apr; hto_r <= hto;
        ap_r <= ap; om_r <= om; cb_r <= cb; rb_r <= rb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) res_r <= res_nxt;
  end

  assign res = res_r;

endmodule
`default_nettype wire

>>> hdl/modem_card_handshake_registers.sv
// top level of the modem card register and handshake block
//
//  channel  dir  beat when           payload
//  in_ch    in   valid && ready      request, offset, data, elapsed, line levels, uart
//  out_ch   out  valid && ready      read data, strobes, line commands, frame, divisor
//  cfg_ch   in   valid && ready      register index, write data (always ready)
//
// one item at a time: each beat steps through take, delay multiply, branch, time advance and
// commit; the millisecond tick count comes from a reciprocal multiply at intake
// an active modem status read adds up to four passes of the shared divider
// (ring cadence, timer rate, timer period, timer phase)
// a finished result sits in the output register while the next beat is taken;
// with out_ready low that next beat waits at commit and in_ready stays low
// reset (rst_n low, synchronous) restores every shadow, timer and config register
`default_nettype none
module modem_card_handshake_registers
  import mcr_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  mcr_in_if.sink   in_ch,
  mcr_out_if.source out_ch,
  mcr_cfg_if.sink  cfg_ch
);

  cmd_t  cmd;
  stat_t stat;
  item_t item;
  res_t  res;

  // config writes are always taken
  assign cfg_ch.ready = 1'b1;

  // pack the input beat
  assign item.req_type    = in_ch.req_type;
  assign item.port_offset = in_ch.port_offset;
  assign item.write_data  = in_ch.write_data;
  assign item.elapsed     = in_ch.elapsed;
  assign item.carrier     = in_ch.carrier;
  assign item.ringing     = in_ch.ringing;
  assign item.connecting  = in_ch.connecting;
  assign item.uart_flags  = in_ch.uart_flags;
  assign item.rx_byte     = in_ch.rx_byte;

  // sequencer owns both handshakes
  mcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath holds the card state and the registered result
  mcr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .item      (item),
    .cfg_we    (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .res       (res)
  );

  // unpack the result beat
  assign out_ch.read_data      = res.read_data;
  assign out_ch.tx_strobe      = res.tx_strobe;
  assign out_ch.rx_strobe      = res.rx_strobe;
  assign out_ch.dial_cmd       = res.dial_cmd;
  assign out_ch.answer_cmd     = res.answer_cmd;
  assign out_ch.hangup_cmd     = res.hangup_cmd;
  assign out_ch.arm_answer_cmd = res.arm_answer_cmd;
  assign out_ch.self_test_loop = res.self_test_loop;
  assign out_ch.data_bits      = res.data_bits;
  assign out_ch.parity_mode    = res.parity_mode;
  assign out_ch.two_stop       = res.two_stop;
  assign out_ch.rate_divisor   = res.rate_divisor;

endmodule
`default_nettype wire

>>> bench/tb_modem_card_handshake_registers.sv
// self-checking bench for the modem card register and handshake block
`timescale 1ns / 1ps
`default_nettype none
module tb_modem_card_handshake_registers;
  import mcr_pkg::*;

  localparam longint unsigned TMASK = 64'h0000_FFFF_FFFF_FFFF;
  localparam int LIMIT = 3000000;
  localparam int DRAIN = 400;

  logic clk;
  logic rst_n;

  mcr_in_if  in_ch ();
  mcr_out_if out_ch ();
  mcr_cfg_if cfg_ch ();

  modem_card_handshake_registers uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // ---------------------------------------------------------------------------
  // shadow of the card: configuration and handshake state
  // ---------------------------------------------------------------------------
  longint unsigned clk_hz;
  bit              dial_ok, answer_ok, modem_here;
  logic [7:0]      c0_sh, rate_sh, c3_sh, div_sh;
  longint unsigned now, cts_at, ring_t0, ap_at, hs_at;
  bit              ap_low, orig, car_was, ring_was;
  bit              lc, lr, ln;                  // line levels of the current beat
  bit              pd, pa, ph, parm;            // command pulses of the current beat

  function automatic longint unsigned ms_tick();
    return clk_hz / 1000;
  endfunction

  function automatic longint unsigned deadline(longint unsigned ms);
    return (now + ms * ms_tick()) & TMASK;
  endfunction

  function automatic bit st_on();
    return c3_sh[C3_DTR_BIT] && !c3_sh[C3_ST_BIT];
  endfunction

  function automatic bit active();
    return modem_here && (dial_ok || answer_ok) && !st_on();
  endfunction

  function automatic bit line_idle();
    return !lr && !ln && !lc;
  endfunction

  function automatic logic [7:0] status_byte();
    logic [7:0] s;
    longint unsigned per, hz, tper;
    bit ring_lit, tim;
    s = 8'h00;
    if (!active()) return STATUS_FIXED;
    if (!(dial_ok && c0_sh[0] && !lc && !ln)) s |= 8'h01;
    // ring cadence: 2 s on out of every 6 s since the latest ring edge
    per = 6000 * ms_tick();
    ring_lit = (per == 0) ? 1'b1 : ((((now - ring_t0) & TMASK) % per) < 2000 * ms_tick());
    if (!(lr && ring_lit)) s |= 8'h02;
    if (!(cts_at != 0 && now >= cts_at && lc)) s |= 8'h04;
    if (!ap_low) s |= 8'h10;
    if (orig) s |= 8'h40;
    // timer pulse: high for the first 40% of each period
    tim = 1'b0;
    if (rate_sh != 0) begin
      hz = 250000 / (longint'(rate_sh) * 100);
      if (hz != 0) begin
        tper = clk_hz / hz;
        if (tper != 0) tim = (now % tper) < tper * 40 / 100;
      end
    end
    if (tim) s |= 8'h80;
    return s;
  endfunction

  function automatic void latch_ap();
    if ((c0_sh[1:0] != 0) && c3_sh[C3_DTR_BIT]) ap_low = 1'b1;
  endfunction

  function automatic void handshake_tick();
    if (!active()) return;
    if (lc && !car_was) begin
      cts_at = deadline(64'(orig ? DUR_CTS_ORIG : DUR_CTS_ANS));
      hs_at  = 0;
    end else if (!lc && car_was) begin
      cts_at = 0;
      if (ap_low) ap_at = deadline(64'(DUR_AP_RESET));
    end
    car_was = lc;
    if (lr && !ring_was) ring_t0 = now;
    ring_was = lr;
    if (ap_at != 0 && now >= ap_at) begin
      ap_low = 1'b0;
      ap_at  = 0;
    end
    if (hs_at != 0 && now >= hs_at) begin
      ph     = 1'b1;
      ap_low = 1'b0;
      hs_at  = 0;
      cts_at = 0;
    end
    if (ap_low && !lc && cts_at == 0) begin
      if (hs_at == 0) hs_at = deadline(64'(DUR_NO_HSHAKE));
    end else if (lc) begin
      hs_at = 0;
    end
  endfunction

  function automatic void ctrl0_written(logic [7:0] was);
    if (active()) begin
      if (c0_sh[1] && !was[1] && lr) begin
        pa   = 1'b1;
        orig = 1'b0;
      end
      if (c0_sh[0] && !was[0] && c3_sh[C3_DTR_BIT] && dial_ok && !c0_sh[1] && line_idle()) begin
        pd   = 1'b1;
        orig = 1'b1;
      end
      latch_ap();
    end
    handshake_tick();
  endfunction

  function automatic void ctrl3_written(logic [7:0] was);
    if (active()) begin
      if (c3_sh[C3_DTR_BIT] && !was[C3_DTR_BIT]) begin
        if (answer_ok) parm = 1'b1;
        if (c0_sh[0] && dial_ok && line_idle()) begin
          pd   = 1'b1;
          orig = 1'b1;
        end
      end
      if (!c3_sh[C3_DTR_BIT] && was[C3_DTR_BIT]) begin
        ph     = 1'b1;
        ap_low = 1'b0;
        cts_at = 0;
        ap_at  = 0;
        hs_at  = 0;
      end
      latch_ap();
    end
    handshake_tick();
  endfunction

  // expected result of one accepted beat; advances the shadow state
  function automatic res_t card_response(item_t it);
    res_t r;
    logic [7:0] was;
    r = '0;
    lc = it.carrier;
    lr = it.ringing;
    ln = it.connecting;
    pd = 0; pa = 0; ph = 0; parm = 0;
    case (it.req_type)
      REQ_READ: begin
        case (it.port_offset)
          PORT_CTRL0: r.read_data = {2'b00, it.uart_flags[4:2], it.uart_flags[0],
                                     it.uart_flags[1], it.uart_flags[0]};
          PORT_DATA: begin
            r.read_data = it.rx_byte;
            r.rx_strobe = 1'b1;
          end
          PORT_RATE: r.read_data = status_byte();
          default:   r.read_data = READ_EMPTY;
        endcase
      end
      REQ_WRITE: begin
        case (it.port_offset)
          PORT_DATA: r.tx_strobe = 1'b1;
          PORT_RATE: begin
            rate_sh = it.write_data;
            if (it.write_data != 0) div_sh = it.write_data;
          end
          PORT_CTRL3: begin
            was   = c3_sh;
            c3_sh = it.write_data;
            ctrl3_written(was);
          end
          default: begin
            was   = c0_sh;
            c0_sh = it.write_data;
            ctrl0_written(was);
          end
        endcase
      end
      REQ_TIME: begin
        now = (now + it.elapsed) & TMASK;
        handshake_tick();
      end
      default: ;  // unused request: nothing happens
    endcase
    r.dial_cmd       = pd;
    r.answer_cmd     = pa;
    r.hangup_cmd     = ph;
    r.arm_answer_cmd = parm;
    r.self_test_loop = st_on();
    r.data_bits      = 4'd5 + {2'b00, c0_sh[3:2]};
    r.parity_mode    = c0_sh[4] ? 2'd0 : (c0_sh[5] ? 2'd2 : 2'd1);
    r.two_stop       = c0_sh[6];
    r.rate_divisor   = div_sh;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus store, expected results, scoreboard counters
  // ---------------------------------------------------------------------------
  item_t pending_q[$];
  res_t  expect_q[$];
  int    mismatches;
  int    results_seen;
  int    idle_pct;
  bit    hold_used;
  int    hold_left;
  // sticky line levels so calls actually progress
  bit    g_car, g_ring, g_conn;

  function automatic void queue_item(item_t it);
    pending_q = {pending_q, it};
  endfunction

  // ---------------------------------------------------------------------------
  // clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // input driver: one beat offered per cycle unless idling or held while ready is low
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        item_t nx;
        nx = pending_q.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.req_type    <= nx.req_type;
        in_ch.port_offset <= nx.port_offset;
        in_ch.write_data  <= nx.write_data;
        in_ch.elapsed     <= nx.elapsed;
        in_ch.carrier     <= nx.carrier;
        in_ch.ringing     <= nx.ringing;
        in_ch.connecting  <= nx.connecting;
        in_ch.uart_flags  <= nx.uart_flags;
        in_ch.rx_byte     <= nx.rx_byte;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result sink: random stalls plus one long hold-off that backs the card up
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_used && results_seen >= 300) begin
      hold_used    <= 1'b1;
      hold_left    <= 1500;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on every accepted input beat, check every output beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    item_t it;
    res_t  got, exp_r, pred;
    if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_CLOCK_HZ:      clk_hz     = 64'(cfg_ch.data);
        CFG_CAN_DIAL:      dial_ok    = cfg_ch.data[0];
        CFG_CAN_ANSWER:    answer_ok  = cfg_ch.data[0];
        CFG_MODEM_PRESENT: modem_here = cfg_ch.data[0];
        default: ;
      endcase
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      it = '{in_ch.req_type, in_ch.port_offset, in_ch.write_data, in_ch.elapsed,
             in_ch.carrier, in_ch.ringing, in_ch.connecting, in_ch.uart_flags,
             in_ch.rx_byte};
      pred = card_response(it);
      expect_q = {expect_q, pred};
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.read_data, out_ch.tx_strobe, out_ch.rx_strobe, out_ch.dial_cmd,
              out_ch.answer_cmd, out_ch.hangup_cmd, out_ch.arm_answer_cmd,
              out_ch.self_test_loop, out_ch.data_bits, out_ch.parity_mode,
              out_ch.two_stop, out_ch.rate_divisor};
      results_seen <= results_seen + 1;
      if (expect_q.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        exp_r = expect_q.pop_front();
        // field by field; a report prints the expected and actual beats
        if (got.read_data !== exp_r.read_data || got.tx_strobe !== exp_r.tx_strobe ||
            got.rx_strobe !== exp_r.rx_strobe || got.dial_cmd !== exp_r.dial_cmd ||
            got.answer_cmd !== exp_r.answer_cmd || got.hangup_cmd !== exp_r.hangup_cmd ||
            got.arm_answer_cmd !== exp_r.arm_answer_cmd ||
            got.self_test_loop !== exp_r.self_test_loop ||
            got.data_bits !== exp_r.data_bits || got.parity_mode !== exp_r.parity_mode ||
            got.two_stop !== exp_r.two_stop || got.rate_divisor !== exp_r.rate_divisor) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("result %0d mismatch: expected %p actual %p", results_seen, exp_r, got);
        end
      end
    end
  end

  // watchdog
  int cycles;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic item_t beat(logic [1:0] rt, logic [1:0] po, logic [7:0] wd,
                                 logic [15:0] el);
    item_t it;
    it.req_type    = rt;
    it.port_offset = po;
    it.write_data  = wd;
    it.elapsed     = el;
    it.carrier     = g_car;
    it.ringing     = g_ring;
    it.connecting  = g_conn;
    it.uart_flags  = 5'($urandom_range(31));
    it.rx_byte     = 8'($urandom_range(255));
    return it;
  endfunction

  // control byte biased toward the SH, RI, DTR and ST bits
  function automatic logic [7:0] ctrl_byte();
    logic [7:0] pick[9] = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h40, 8'h50, 8'h41, 8'h42, 8'h00};
    int k;
    k = $urandom_range(9);
    return (k == 9) ? 8'($urandom_range(255)) : pick[k];
  endfunction

  function automatic logic [15:0] time_step();
    case ($urandom_range(3))
      0: return 16'($urandom_range(15));
      1: return 16'($urandom_range(3000));
      2: return 16'($urandom_range(65535));
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic item_t random_beat();
    int r;
    logic [7:0] rates[6] = '{8'd0, 8'd1, 8'd2, 8'd5, 8'd10, 8'd255};
    if ($urandom_range(99) < 8) g_car  = ~g_car;
    if ($urandom_range(99) < 8) g_ring = ~g_ring;
    if ($urandom_range(99) < 5) g_conn = ~g_conn;
    r = $urandom_range(99);
    if (r < 30) begin
      return beat(REQ_READ, ($urandom_range(1) ? PORT_RATE : 2'($urandom_range(3))),
                  8'($urandom_range(255)), 16'($urandom_range(65535)));
    end else if (r < 63) begin
      case ($urandom_range(3))
        0: return beat(REQ_WRITE, PORT_CTRL0, ctrl_byte(), 16'($urandom_range(65535)));
        1: return beat(REQ_WRITE, PORT_CTRL3, ctrl_byte(), 16'($urandom_range(65535)));
        2: return beat(REQ_WRITE, PORT_RATE,
                       $urandom_range(1) ? rates[$urandom_range(5)] : 8'($urandom_range(255)),
                       16'($urandom_range(65535)));
        default: return beat(REQ_WRITE, PORT_DATA, 8'($urandom_range(255)),
                             16'($urandom_range(65535)));
      endcase
    end else if (r < 97) begin
      return beat(REQ_TIME, 2'($urandom_range(3)), 8'($urandom_range(255)), time_step());
    end else begin
      return beat(REQ_SPARE, 2'($urandom_range(3)), 8'($urandom_range(255)),
                  16'($urandom_range(65535)));
    end
  endfunction

  // a call from dial-out or ring-in through to carrier loss, with random timing
  task automatic push_call();
    bit outgoing;
    outgoing = 1'($urandom_range(1));
    g_car = 0; g_conn = 0; g_ring = !outgoing;
    queue_item(beat(REQ_WRITE, PORT_CTRL3, 8'h40, 16'd0));
    queue_item(beat(REQ_WRITE, PORT_CTRL0, outgoing ? 8'h01 : 8'h02, 16'd0));
    queue_item(beat(REQ_READ, PORT_RATE, 8'd0, 16'd0));
    if (outgoing) g_conn = 1;
    queue_item(beat(REQ_TIME, PORT_CTRL0, 8'd0, time_step()));
    g_car = $urandom_range(3) != 0; g_ring = 0; g_conn = 0;
    repeat ($urandom_range(6, 2)) begin
      queue_item(beat(REQ_TIME, PORT_CTRL0, 8'd0, time_step()));
      queue_item(beat(REQ_READ, PORT_RATE, 8'd0, 16'd0));
    end
    g_car = 0;
    repeat ($urandom_range(5, 1)) begin
      queue_item(beat(REQ_TIME, PORT_CTRL0, 8'd0, time_step()));
      queue_item(beat(REQ_READ, PORT_RATE, 8'd0, 16'd0));
    end
    queue_item(beat(REQ_WRITE, $urandom_range(1) ? PORT_CTRL3 : PORT_CTRL0, 8'h00, 16'd0));
  endtask

  task automatic cfg_write(logic [3:0] idx, logic [21:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic settle();
    wait (pending_q.size() == 0);
    @(posedge clk);
    while (in_ch.valid || expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [21:0] hz_set[8] = '{22'd1000, 22'd4000000, 22'd2000, 22'd500,
                               22'd1000, 22'd123456, 22'd4194303, 22'd1000};
    bit [2:0] flg_set[8] = '{3'b111, 3'b011, 3'b101, 3'b111, 3'b001, 3'b110, 3'b111, 3'b111};
    int bursts;
    int n0;
    in_ch.valid = 0; in_ch.req_type = 0; in_ch.port_offset = 0; in_ch.write_data = 0;
    in_ch.elapsed = 0; in_ch.carrier = 0; in_ch.ringing = 0; in_ch.connecting = 0;
    in_ch.uart_flags = 0; in_ch.rx_byte = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0; cfg_ch.index = 0; cfg_ch.data = 0;
    clk_hz = CLOCK_HZ_RESET; dial_ok = 0; answer_ok = 0; modem_here = 0;
    c0_sh = 0; rate_sh = 0; c3_sh = 0; div_sh = 0; now = 0;
    ap_low = 0; orig = 1; cts_at = 0; ring_t0 = 0; ap_at = 0; hs_at = 0;
    car_was = 0; ring_was = 0;
    mismatches = 0; results_seen = 0; cycles = 0; hold_used = 0; idle_pct = 37;
    g_car = 0; g_ring = 0; g_conn = 0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: card absent, frame extremes, divisor rules, every read port
    queue_item(beat(REQ_READ, PORT_RATE, 8'd0, 16'd0));
    queue_item(beat(REQ_READ, PORT_CTRL0, 8'd0, 16'd0));
    for (int p = 0; p < 4; p++) begin
      item_t t;
      t = beat(REQ_READ, 2'(p), 8'hFF, 16'hFFFF);
      t.uart_flags = 5'h1F; t.rx_byte = 8'hFF; t.carrier = 1; t.ringing = 1; t.connecting = 1;
      queue_item(t);
      t.uart_flags = 5'h00; t.rx_byte = 8'h00;
      queue_item(t);
    end
    queue_item(beat(REQ_WRITE, PORT_CTRL0, 8'hFF, 16'd0));
    queue_item(beat(REQ_WRITE, PORT_CTRL0, 8'h2C, 16'd0));
    queue_item(beat(REQ_WRITE, PORT_CTRL0, 8'h00, 16'd0));
    queue_item(beat(REQ_WRITE, PORT_RATE, 8'hFF, 16'd0));
    queue_item(beat(REQ_WRITE, PORT_RATE, 8'h00, 16'd0));     // zero keeps divisor
    queue_item(beat(REQ_READ, PORT_RATE, 8'd0, 16'd0));
    queue_item(beat(REQ_WRITE, PORT_RATE, 8'h01, 16'd0));
    queue_item(beat(REQ_WRITE, PORT_DATA, 8'hA5, 16'd0));
    queue_item(beat(REQ_WRITE, PORT_CTRL3, 8'h40, 16'd0));    // self-test engaged
    queue_item(beat(REQ_WRITE, PORT_CTRL3, 8'hFF, 16'd0));
    queue_item(beat(REQ_SPARE, PORT_CTRL0, 8'hFF, 16'hFFFF)); // unused request
    queue_item(beat(REQ_TIME, PORT_CTRL0, 8'd0, 16'hFFFF));
    queue_item(beat(REQ_WRITE, PORT_CTRL3, 8'h00, 16'd0));
    settle();

    // phases of configuration; phase 2 runs with no idling at all
    for (int ph_i = 0; ph_i < 8; ph_i++) begin
      cfg_write(CFG_CLOCK_HZ, hz_set[ph_i]);
      cfg_write(CFG_CAN_DIAL, 22'(flg_set[ph_i][0]));
      cfg_write(CFG_CAN_ANSWER, 22'(flg_set[ph_i][1]));
      cfg_write(CFG_MODEM_PRESENT, 22'(flg_set[ph_i][2]));
      idle_pct = (ph_i == 2) ? 0 : 37;
      bursts = 0;
      while (bursts < 190) begin
        n0 = pending_q.size();
        if ($urandom_range(99) < 70) begin
          push_call();
        end else begin
          repeat (8) queue_item(random_beat());
        end
        bursts += pending_q.size() - n0;
      end
      settle();
    end

    if (mismatches == 0 && expect_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
hdl/mcr_pkg.sv
hdl/mcr_if.sv
hdl/mcr_div.sv
hdl/mcr_ctrl.sv
hdl/mcr_dp.sv
hdl/modem_card_handshake_registers.sv
bench/tb_modem_card_handshake_registers.sv
